>>> hdl/atrpc_pkg.sv
`timescale 1ns / 1ps
// types, codes and sizes for the at response prefix capture block
// no dependencies

package atrpc_pkg;

  localparam int BufferDepth = 512;
  localparam int CntW        = $clog2(BufferDepth);
  localparam int IndexW      = 9;
  localparam int PatBytes    = 8;
  localparam int PatW        = 8 * PatBytes;
  localparam int PosW        = 4;
  localparam int LenW        = 4;

  localparam logic [7:0] ChO = 8'h4F;
  localparam logic [7:0] ChK = 8'h4B;

  localparam logic [1:0] PhaseCodeDone    = 2'd0;
  localparam logic [1:0] PhaseCodeMatch   = 2'd1;
  localparam logic [1:0] PhaseCodeCapture = 2'd2;

  typedef enum logic [1:0] {
    RegPattern = 2'd0,
    RegLength  = 2'd1,
    RegCapture = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    WrNone = 2'd0,
    WrData = 2'd1,
    WrTerm = 2'd2
  } wr_kind_e;

  typedef enum logic [2:0] {
    PhDone    = 3'b001,
    PhMatch   = 3'b010,
    PhCapture = 3'b100
  } phase_e;

  typedef struct packed {
    wr_kind_e          kind;
    logic [IndexW-1:0] index;
    logic [7:0]        data;
    logic [1:0]        phase;
    logic              finished;
    logic              last;
  } result_t;

  function automatic logic [1:0] phase_code(phase_e ph);
    logic [1:0] code;
    case (ph)
      PhMatch:   code = PhaseCodeMatch;
      PhCapture: code = PhaseCodeCapture;
      default:   code = PhaseCodeDone;
    endcase
    return code;
  endfunction

endpackage

>>> hdl/at_response_prefix_capture.sv
`timescale 1ns / 1ps
// at response prefix capture: prefix match and capture of received bytes, uses atrpc_pkg
// the first result is registered and presented in the cycle after the input transfer
// throughput: one input transfer per cycle while the output accepts results, each giving one or two result transfers
// an item with a data and a terminator write holds the input until its first result is taken
// two-entry result buffer decouples the sides
// reset: asynchronous, active low; clears parser state, result buffer and registers

module at_response_prefix_capture (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // write_index, write_data, parse_phase, finished, zeros
  output logic [1:0]  m_axis_tuser,   // write_kind
  output logic        m_axis_tlast    // last
);

  logic [atrpc_pkg::PatW-1:0] pattern_q;
  logic [atrpc_pkg::LenW-1:0] length_q;
  logic                       capture_en_q;

  atrpc_pkg::phase_e          phase_q, phase_d;
  logic [atrpc_pkg::PosW-1:0] pos_q, pos_d;
  logic [atrpc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [7:0]                 prev_q, prev_d;

  atrpc_pkg::result_t slot0_q, slot1_q, res0, res1;
  logic               slot0_v_q, slot1_v_q, two_res;

  logic in_acc, out_acc;

  logic [atrpc_pkg::PosW-1:0] eff_len, pos_upd;
  logic [7:0]                 rx_b, pat_cur, pat_first;
  logic                       fin, data_wr, term_wr, match_done;
  logic [atrpc_pkg::CntW-1:0] term_idx;

  assign s_axis_tready = !slot0_v_q || (m_axis_tready && !slot1_v_q);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q    <= '0;
      length_q     <= '0;
      capture_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (atrpc_pkg::cfg_reg_e'(cfg_index_i))
        atrpc_pkg::RegPattern: pattern_q    <= cfg_data_i;
        atrpc_pkg::RegLength:  length_q     <= cfg_data_i[atrpc_pkg::LenW-1:0];
        atrpc_pkg::RegCapture: capture_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // step logic
  assign rx_b      = s_axis_tdata;
  assign eff_len   = (length_q > atrpc_pkg::PosW'(atrpc_pkg::PatBytes)) ?
                     atrpc_pkg::PosW'(atrpc_pkg::PatBytes) : length_q;
  assign pat_cur   = pattern_q[8*pos_q[2:0] +: 8];
  assign pat_first = pattern_q[7:0];

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    prev_d     = prev_q;
    fin        = 1'b0;
    data_wr    = 1'b0;
    term_wr    = 1'b0;
    match_done = 1'b0;
    pos_upd    = pos_q;
    term_idx   = cnt_q;
    if (s_axis_tuser) begin
      phase_d = atrpc_pkg::PhMatch;
      pos_d   = '0;
    end else begin
      prev_d = rx_b;
      case (phase_q)
        atrpc_pkg::PhMatch: begin
          if (pos_q < eff_len) begin
            if (rx_b == pat_cur) begin
              pos_upd = pos_q + atrpc_pkg::PosW'(1);
            end else if (rx_b == pat_first) begin
              pos_upd = atrpc_pkg::PosW'(1);
            end else begin
              pos_upd = '0;
            end
            match_done = (pos_upd >= eff_len);
          end else begin
            match_done = 1'b1;
          end
          pos_d = pos_upd;
          if (match_done) begin
            cnt_d = '0;
            if (capture_en_q) begin
              phase_d = atrpc_pkg::PhCapture;
            end else begin
              phase_d = atrpc_pkg::PhDone;
              fin     = 1'b1;
            end
          end
        end
        atrpc_pkg::PhCapture: begin
          if (cnt_q < atrpc_pkg::CntW'(atrpc_pkg::BufferDepth - 1)) begin
            data_wr  = 1'b1;
            term_idx = cnt_q + atrpc_pkg::CntW'(1);
            cnt_d    = term_idx;
          end
          if (rx_b == atrpc_pkg::ChK && prev_q == atrpc_pkg::ChO) begin
            term_wr = 1'b1;
            phase_d = atrpc_pkg::PhDone;
            fin     = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result assembly
  always_comb begin
    res0.kind     = atrpc_pkg::WrNone;
    res0.index    = '0;
    res0.data     = '0;
    res0.phase    = atrpc_pkg::phase_code(phase_d);
    res0.finished = fin;
    res0.last     = !(data_wr && term_wr);
    if (data_wr) begin
      res0.kind  = atrpc_pkg::WrData;
      res0.index = atrpc_pkg::IndexW'(cnt_q);
      res0.data  = rx_b;
    end else if (term_wr) begin
      res0.kind  = atrpc_pkg::WrTerm;
      res0.index = atrpc_pkg::IndexW'(term_idx);
    end
    res1.kind     = atrpc_pkg::WrTerm;
    res1.index    = atrpc_pkg::IndexW'(term_idx);
    res1.data     = '0;
    res1.phase    = atrpc_pkg::phase_code(phase_d);
    res1.finished = fin;
    res1.last     = 1'b1;
  end

  assign two_res = data_wr && term_wr;

  // state and result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= atrpc_pkg::PhDone;
      pos_q     <= '0;
      cnt_q     <= '0;
      prev_q    <= '0;
      slot0_v_q <= 1'b0;
      slot1_v_q <= 1'b0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      prev_q    <= prev_d;
      slot0_v_q <= 1'b1;
      slot1_v_q <= two_res;
    end else if (out_acc) begin
      slot0_v_q <= slot1_v_q;
      slot1_v_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot0_q <= res0;
      slot1_q <= res1;
    end else if (out_acc) begin
      slot0_q <= slot1_q;
    end
  end

  assign m_axis_tvalid = slot0_v_q;
  assign m_axis_tuser  = slot0_q.kind;
  assign m_axis_tlast  = slot0_q.last;
  assign m_axis_tdata  = {4'b0000, slot0_q.finished, slot0_q.phase,
                          slot0_q.data, slot0_q.index};

  // checks
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot1_v_q |-> slot0_v_q)
    else $error("second result held without a first");

  a_second_is_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot1_v_q |-> (slot1_q.kind == atrpc_pkg::WrTerm && slot1_q.last &&
                   slot0_q.kind == atrpc_pkg::WrData && !slot0_q.last))
    else $error("pending second result is not a terminator after data");

  a_not_last_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot0_v_q && !slot0_q.last) |-> slot1_v_q)
    else $error("non-final result without a pending successor");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= atrpc_pkg::PosW'(atrpc_pkg::PatBytes))
    else $error("match position beyond pattern size");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= atrpc_pkg::CntW'(atrpc_pkg::BufferDepth - 1))
    else $error("capture count beyond buffer");

endmodule
